// ----- hdl/rrbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrbc_pkg
// Shared types and constants for the cartridge ROM/RAM bank controller.
// ----------------------------------------------------------------------------
package rrbc_pkg;

  // Bus access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Address windows, decoded from address[15:13]
  localparam logic [2:0] RNG_ENABLE  = 3'b000;  // 0x0000-0x1FFF
  localparam logic [2:0] RNG_ROM_SEL = 3'b001;  // 0x2000-0x3FFF
  localparam logic [2:0] RNG_RAM_SEL = 3'b010;  // 0x4000-0x5FFF
  localparam logic [2:0] RNG_RAM     = 3'b101;  // 0xA000-0xBFFF

  localparam logic [3:0]  RAM_EN_KEY      = 4'hA;
  localparam logic [7:0]  RAM_CLOSED_DATA = 8'hFF;
  localparam logic [19:0] BANK0_END       = 20'h04000;
  localparam int unsigned ROM_OFS_W       = 14;   // 16 KiB ROM bank
  localparam int unsigned RAM_OFS_W       = 13;   // 8 KiB RAM bank
  localparam int unsigned MEM_AW_MAX      = 15;   // largest store index width

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        from_rom;
    logic [19:0] rom_address;
  } rsp_t;

  // Request to the RAM store
  typedef struct packed {
    logic                  we;
    logic [MEM_AW_MAX-1:0] addr;
    logic [7:0]            wdata;
  } mem_req_t;

  // What the result stage needs to know about the beat in flight
  typedef struct packed {
    logic        valid;
    logic        ram_rd;
    logic        ram_en;
    logic        from_rom;
    logic [19:0] rom_address;
  } stage_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

endpackage
`default_nettype wire

// ----- hdl/rrbc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrbc_ram
// Single-port byte store, synchronous write, registered read.
// ----------------------------------------------------------------------------
module rrbc_ram #(
  parameter int unsigned RAM_BYTES = 32768
) (
  input  wire logic              clk_i,
  input  wire rrbc_pkg::mem_req_t req_i,
  output logic [7:0]             rdata_o
);

  localparam int unsigned AW = $clog2(RAM_BYTES);

  logic [7:0] mem [RAM_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr[AW-1:0]] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr[AW-1:0]];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/rrbc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrbc_ctrl
// Bank registers, address decode, store addressing and the reset clear pass.
// ----------------------------------------------------------------------------
module rrbc_ctrl #(
  parameter int unsigned RAM_BYTES = 32768
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire rrbc_pkg::req_t     req_i,
  output logic                    busy,
  output rrbc_pkg::mem_req_t      mem_req_o,
  output rrbc_pkg::stage_t        stage_o
);

  localparam int unsigned AW    = $clog2(RAM_BYTES);
  localparam int unsigned RAW_W = rrbc_pkg::MEM_AW_MAX;
  localparam int unsigned QMAX  = (32768 - 1) / RAM_BYTES;

  rrbc_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [4:0]       rom_bank_q, rom_bank_d;
  logic [1:0]       ram_bank_q, ram_bank_d;
  logic             ram_en_q, ram_en_d;

  logic             accept;
  logic [2:0]       rng;
  logic [RAW_W-1:0] raw_idx;
  logic [RAW_W-1:0] wrap_sub;
  logic [RAW_W-1:0] ram_idx;
  logic [19:0]      banked_addr;

  // Busy for the whole clear pass, reset included.
  assign busy   = (state_q == rrbc_pkg::ST_CLEAR);
  assign accept = start && !busy;
  assign rng    = req_i.address[15:13];

  // Bank-relative index, then wrap at the store size (value < 2^15).
  assign raw_idx = {ram_bank_q, req_i.address[rrbc_pkg::RAM_OFS_W-1:0]};

  always_comb begin
    wrap_sub = '0;
    for (int unsigned k = 1; k <= QMAX; k++) begin
      if ({1'b0, raw_idx} >= 16'(k * RAM_BYTES)) begin
        wrap_sub = RAW_W'(k * RAM_BYTES);
      end
    end
  end

  assign ram_idx = raw_idx - wrap_sub;

  assign banked_addr = {1'b0, rom_bank_q, {rrbc_pkg::ROM_OFS_W{1'b0}}}
                     + {4'b0, req_i.address} - rrbc_pkg::BANK0_END;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rrbc_pkg::ST_CLEAR;
      clr_cnt_q  <= '0;
      rom_bank_q <= 5'd1;
      ram_bank_q <= '0;
      ram_en_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      rom_bank_q <= rom_bank_d;
      ram_bank_q <= ram_bank_d;
      ram_en_q   <= ram_en_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    rom_bank_d = rom_bank_q;
    ram_bank_d = ram_bank_q;
    ram_en_d   = ram_en_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.addr  = RAW_W'(ram_idx[AW-1:0]);
    mem_req_o.wdata = req_i.write_data;

    stage_o.valid       = accept;
    stage_o.ram_rd      = 1'b0;
    stage_o.ram_en      = ram_en_q;
    stage_o.from_rom    = 1'b0;
    stage_o.rom_address = '0;

    case (state_q)
      rrbc_pkg::ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = RAW_W'(clr_cnt_q);
        mem_req_o.wdata = '0;
        clr_cnt_d       = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(RAM_BYTES - 1)) begin
          state_d = rrbc_pkg::ST_RUN;
        end
      end
      rrbc_pkg::ST_RUN: begin
        if (accept && req_i.op == rrbc_pkg::OP_WRITE) begin
          case (rng)
            rrbc_pkg::RNG_ENABLE: begin
              ram_en_d = (req_i.write_data[3:0] == rrbc_pkg::RAM_EN_KEY);
            end
            rrbc_pkg::RNG_ROM_SEL: begin
              rom_bank_d = (req_i.write_data[4:0] == 5'd0) ? 5'd1
                                                          : req_i.write_data[4:0];
            end
            rrbc_pkg::RNG_RAM_SEL: begin
              ram_bank_d = req_i.write_data[1:0];
            end
            rrbc_pkg::RNG_RAM: begin
              mem_req_o.we = ram_en_q;
            end
            default: begin
            end
          endcase
        end else if (accept) begin
          if (req_i.address[15:14] == 2'b00) begin
            stage_o.from_rom    = 1'b1;
            stage_o.rom_address = {4'b0, req_i.address};
          end else if (rng == rrbc_pkg::RNG_RAM) begin
            stage_o.ram_rd = 1'b1;
          end else begin
            stage_o.from_rom    = 1'b1;
            stage_o.rom_address = banked_addr;
          end
        end
      end
      default: begin
        state_d = rrbc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/rom_ram_bank_controller_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// done_o strobes for each accepted start beat; the store read and the result
//   stage registers form the one registered step between them.
// Throughput: one beat per cycle once the clear pass is over.
// Reset: banks to ROM 1 / RAM 0, RAM closed; then a clear pass writes zero to
//   every store byte, busy high throughout.
// The receiver cannot stall: each result shows for one cycle under done_o.
// ----------------------------------------------------------------------------
// rom_ram_bank_controller_top
// Cartridge bus bank controller: bank select writes, external RAM, ROM
// address translation.
// ----------------------------------------------------------------------------
module rom_ram_bank_controller_top #(
  parameter int unsigned RAM_BYTES = 32768
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire rrbc_pkg::req_t req_i,
  output logic                busy,
  output logic                done_o,
  output rrbc_pkg::rsp_t      rsp_o
);

  rrbc_pkg::mem_req_t mem_req;
  rrbc_pkg::stage_t   stage;
  logic [7:0]         ram_rdata;

  // Result stage registers; payload carries no reset
  logic        done_q;
  logic        ram_rd_q;
  logic        ram_en_q;
  logic        from_rom_q;
  logic [19:0] rom_addr_q;

  // Control: banks, decode, store addressing, clear sequencer
  rrbc_ctrl #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .req_i     (req_i),
    .busy      (busy),
    .mem_req_o (mem_req),
    .stage_o   (stage)
  );

  // External RAM; read data lands with the result stage
  rrbc_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ram_rd_q   <= stage.ram_rd;
    ram_en_q   <= stage.ram_en;
    from_rom_q <= stage.from_rom;
    rom_addr_q <= stage.rom_address;
  end

  // A closed RAM reads as all ones; non-RAM results carry zero data.
  assign done_o            = done_q;
  assign rsp_o.read_data   = ram_rd_q ? (ram_en_q ? ram_rdata : rrbc_pkg::RAM_CLOSED_DATA)
                                      : 8'h00;
  assign rsp_o.from_rom    = from_rom_q;
  assign rsp_o.rom_address = rom_addr_q;

  // No result may come out while the clear pass runs.
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result during clear pass");

  // Every result comes in the cycle after an accepted beat.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without accepted beat");

  // ROM translation only answers reads.
  a_rom_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.from_rom) |-> ($past(req_i.op) == rrbc_pkg::OP_READ))
    else $error("ROM result for a write");

  // RAM data and ROM translation never share a result.
  a_data_xor_rom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.from_rom) |-> (rsp_o.read_data == 8'h00))
    else $error("ROM result with data");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Bus access checks for rom_ram_bank_controller_top: a short table of
// directed accesses, then about 1700 random reads and writes with random
// start gaps. Results are held to typed rows or a bank model kept here.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RAM_SIZE   = 32768;
  localparam int unsigned RAND_BEATS = 1700;
  // Clear pass plus every beat at its longest gap, taken several times over
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;

  // One row of the directed table. Where 'typed' is set, the expected
  // result is given in the row; otherwise the model supplies it.
  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        typed;
    logic [7:0]  read_data;
    logic        from_rom;
    logic [19:0] rom_address;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 27;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // Out of reset: ROM bank 1, RAM bank 0, RAM closed
    '{rrbc_pkg::OP_READ,  16'h0000, 8'h00, 1'b1, 8'h00, 1'b1, 20'h00000},
    '{rrbc_pkg::OP_READ,  16'h3FFF, 8'hFF, 1'b1, 8'h00, 1'b1, 20'h03FFF},
    '{rrbc_pkg::OP_READ,  16'h4000, 8'h00, 1'b1, 8'h00, 1'b1, 20'h04000},
    '{rrbc_pkg::OP_READ,  16'h8000, 8'h00, 1'b1, 8'h00, 1'b1, 20'h08000},
    '{rrbc_pkg::OP_READ,  16'hFFFF, 8'h00, 1'b1, 8'h00, 1'b1, 20'h0FFFF},
    '{rrbc_pkg::OP_READ,  16'hA000, 8'h00, 1'b1, 8'hFF, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_READ,  16'hBFFF, 8'h00, 1'b1, 8'hFF, 1'b0, 20'h00000},
    // Top ROM bank, then masked-zero select falls back to bank 1
    '{rrbc_pkg::OP_WRITE, 16'h3FFF, 8'hFF, 1'b1, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_READ,  16'h4000, 8'h00, 1'b1, 8'h00, 1'b1, 20'h7C000},
    '{rrbc_pkg::OP_READ,  16'hFFFF, 8'h00, 1'b1, 8'h00, 1'b1, 20'h87FFF},
    '{rrbc_pkg::OP_WRITE, 16'h2000, 8'hE0, 1'b1, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_READ,  16'h5ABC, 8'h00, 1'b1, 8'h00, 1'b1, 20'h05ABC},
    '{rrbc_pkg::OP_WRITE, 16'h2000, 8'h00, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_WRITE, 16'h2ABC, 8'h10, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_READ,  16'hC000, 8'h00, 1'b0, 8'h00, 1'b0, 20'h00000},
    // Open RAM, store in bank 0 and bank 3
    '{rrbc_pkg::OP_WRITE, 16'h1FFF, 8'h5A, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_WRITE, 16'hA000, 8'hA5, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_READ,  16'hA000, 8'h00, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_WRITE, 16'h5FFF, 8'hFF, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_WRITE, 16'hBFFF, 8'h3C, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_READ,  16'hA000, 8'h00, 1'b0, 8'h00, 1'b0, 20'h00000},
    // Close RAM: stores dropped, reads give the closed value
    '{rrbc_pkg::OP_WRITE, 16'h0000, 8'hAB, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_WRITE, 16'hBFFF, 8'h77, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_READ,  16'hBFFF, 8'h00, 1'b1, 8'hFF, 1'b0, 20'h00000},
    // Mode window write is ignored; reopen and read back the kept byte
    '{rrbc_pkg::OP_WRITE, 16'h6000, 8'hFF, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_WRITE, 16'h1000, 8'h0A, 1'b0, 8'h00, 1'b0, 20'h00000},
    '{rrbc_pkg::OP_READ,  16'hBFFF, 8'h00, 1'b0, 8'h00, 1'b0, 20'h00000}
  };

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  rrbc_pkg::req_t req;
  logic           busy;
  logic           done_o;
  rrbc_pkg::rsp_t rsp;

  // Model state of the bank controller
  logic [4:0] rom_bank_m;
  logic [1:0] ram_bank_m;
  logic       ram_open_m;
  logic [7:0] ram_shadow [RAM_SIZE];

  rrbc_pkg::rsp_t rsp_expect_q [$];
  int unsigned    err_cnt;
  int unsigned    cycle_cnt;
  logic           burst;

  rom_ram_bank_controller_top #(
    .RAM_BYTES(RAM_SIZE)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog: covers the clear pass and the slowest legal run many times over.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Index into the RAM: bank * 8 KiB plus window offset, wrapped at RAM size.
  function automatic int unsigned ram_slot(input logic [1:0] bank,
                                           input logic [15:0] address);
    int unsigned idx;
    idx = int'(bank) * 32'h2000 + int'(address[12:0]);
    return idx % RAM_SIZE;
  endfunction

  // Work out the result of one bus beat and move the model state on.
  task automatic bank_ctrl_predict(input rrbc_pkg::req_t acc,
                                   output rrbc_pkg::rsp_t res);
    logic [31:0] lin;
    logic [2:0]  win;
    win = acc.address[15:13];
    res = '0;
    if (acc.op == rrbc_pkg::OP_WRITE) begin
      if (win == rrbc_pkg::RNG_ENABLE) begin
        ram_open_m = (acc.write_data[3:0] == rrbc_pkg::RAM_EN_KEY);
      end else if (win == rrbc_pkg::RNG_ROM_SEL) begin
        rom_bank_m = (acc.write_data[4:0] == 5'd0) ? 5'd1 : acc.write_data[4:0];
      end else if (win == rrbc_pkg::RNG_RAM_SEL) begin
        ram_bank_m = acc.write_data[1:0];
      end else if (win == rrbc_pkg::RNG_RAM && ram_open_m) begin
        ram_shadow[ram_slot(ram_bank_m, acc.address)] = acc.write_data;
      end
    end else if (acc.address < 16'h4000) begin
      res.from_rom    = 1'b1;
      res.rom_address = {4'd0, acc.address};
    end else if (win == rrbc_pkg::RNG_RAM) begin
      res.read_data = ram_open_m ? ram_shadow[ram_slot(ram_bank_m, acc.address)]
                                 : rrbc_pkg::RAM_CLOSED_DATA;
    end else begin
      lin = {27'd0, rom_bank_m} * 32'h4000 + {16'd0, acc.address} - 32'h4000;
      res.from_rom    = 1'b1;
      res.rom_address = lin[19:0];
    end
  endtask

  // Drive one beat from a falling edge, hold it until accepted, leave the
  // driver at the next falling edge. Prediction is queued at acceptance.
  task automatic issue_beat(input rrbc_pkg::req_t acc, input logic typed,
                            input rrbc_pkg::rsp_t want);
    rrbc_pkg::rsp_t pred;
    start <= 1'b1;
    req   <= acc;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    bank_ctrl_predict(acc, pred);
    rsp_expect_q.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  // Random gap after a beat; start goes low only when a gap is taken, so it
  // never gets two assignments in one step.
  task automatic beat_gap();
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Random beat, weighted toward sequences that open RAM, pick banks and
  // then hit the RAM window, so stores are read back often.
  function automatic rrbc_pkg::req_t rand_beat();
    rrbc_pkg::req_t acc;
    int unsigned    pick;
    logic [12:0]    ofs;
    pick = $urandom_range(0, 99);
    acc.op         = rrbc_pkg::OP_WRITE;
    acc.address    = 16'($urandom);
    acc.write_data = 8'($urandom);
    ofs = ($urandom_range(0, 9) < 6) ? 13'($urandom_range(0, 15)) | {2'($urandom), 11'd0}
                                     : 13'($urandom);
    if (pick < 8) begin
      acc.address[15:13] = rrbc_pkg::RNG_ENABLE;
      if ($urandom_range(0, 9) < 7) acc.write_data[3:0] = rrbc_pkg::RAM_EN_KEY;
    end else if (pick < 16) begin
      acc.address[15:13] = rrbc_pkg::RNG_ROM_SEL;
      if ($urandom_range(0, 6) == 0) acc.write_data[4:0] = 5'd0;
    end else if (pick < 22) begin
      acc.address[15:13] = rrbc_pkg::RNG_RAM_SEL;
    end else if (pick < 26) begin
      // whatever window it lands in
    end else if (pick < 50) begin
      acc.address = {rrbc_pkg::RNG_RAM, ofs};
    end else if (pick < 75) begin
      acc.op      = rrbc_pkg::OP_READ;
      acc.address = {rrbc_pkg::RNG_RAM, ofs};
    end else if (pick < 95) begin
      acc.op = rrbc_pkg::OP_READ;
    end else begin
      acc.op = 1'($urandom);
    end
    return acc;
  endfunction

  // Result side: one strobe, one result, compared against the oldest one due.
  always @(posedge clk_i) begin
    rrbc_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (rsp_expect_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: %h", rsp));
      end else begin
        want = rsp_expect_q.pop_front();
        if (rsp.read_data !== want.read_data)
          flag_mismatch($sformatf("read_data %h, want %h", rsp.read_data, want.read_data));
        if (rsp.from_rom !== want.from_rom)
          flag_mismatch($sformatf("from_rom %b, want %b", rsp.from_rom, want.from_rom));
        if (rsp.rom_address !== want.rom_address)
          flag_mismatch($sformatf("rom_address %h, want %h",
                                  rsp.rom_address, want.rom_address));
      end
    end
  end

  initial begin
    rrbc_pkg::req_t acc;
    rrbc_pkg::rsp_t want;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req        = '0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    burst      = 1'b0;
    rom_bank_m = 5'd1;
    ram_bank_m = 2'd0;
    ram_open_m = 1'b0;
    foreach (ram_shadow[i]) ram_shadow[i] = 8'h00;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // busy covers the clear pass; the first beat simply waits it out

    // Directed table
    foreach (DIR_TAB[i]) begin
      acc  = '{op: DIR_TAB[i].op, address: DIR_TAB[i].address,
               write_data: DIR_TAB[i].write_data};
      want = '{read_data: DIR_TAB[i].read_data, from_rom: DIR_TAB[i].from_rom,
               rom_address: DIR_TAB[i].rom_address};
      issue_beat(acc, DIR_TAB[i].typed, want);
      beat_gap();
    end

    // Random beats; now and then a back-to-back stretch with no gaps
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      issue_beat(rand_beat(), 1'b0, '0);
      beat_gap();
    end
    start <= 1'b0;

    while (rsp_expect_q.size() != 0) @(posedge clk_i);
    // Catch any stray strobe after the last expected result
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
